### rtl/core/atoiab_pkg.sv
// Package for the any-base ASCII to integer converter: character codes,
// register indexes, reset values and the parse phase type. No dependencies.
package atoiab_pkg;

  localparam int MAX_DIGITS_DEF = 16;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 64;
  localparam int LENREG_W = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LEN  = 2'd2;

  // "01234567", "89", base ten
  localparam logic [CFG_W-1:0]    ALPHA_LOW_RST  = 64'h3736353433323130;
  localparam logic [CFG_W-1:0]    ALPHA_HIGH_RST = 64'h0000000000003938;
  localparam logic [LENREG_W-1:0] ALPHA_LEN_RST  = 5'd10;

  typedef enum logic [3:0] {
    PH_SPACE  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

endpackage

### rtl/core/ascii_to_integer_any_base.sv
// Top level of the any-base ASCII to integer converter.
// Depends on atoiab_pkg for character codes, register indexes and types.
//
// Takes one character per transaction and gives one signed 32-bit result on
// the character marked is_last; sustained rate is one character per cycle.
// Each character is matched against the alphabet registers in parallel on
// its way into the input register, and the parse step (multiply-accumulate)
// runs from that register in the next cycle; a result is written to the output
// register when its last character leaves the input register. A waiting result
// stalls only a following last character, which then holds off the input.
// The alphabet validity flag is recomputed every cycle from the registers,
// so configuration must be written while the block is idle.
module ascii_to_integer_any_base #(
  parameter int MAX_DIGITS = atoiab_pkg::MAX_DIGITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [atoiab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [atoiab_pkg::CFG_W-1:0]         cfg_data,
  // character input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [atoiab_pkg::CHAR_W-1:0]        char_code,
  input  logic                                 is_last,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [atoiab_pkg::VALUE_W-1:0] value,
  output logic                                 valid_res
);

  localparam int DIGIT_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int LEN_W   = $clog2(MAX_DIGITS + 1);
  localparam int CW      = atoiab_pkg::CHAR_W;
  localparam int VW      = atoiab_pkg::VALUE_W;

  // configuration registers
  logic [atoiab_pkg::CFG_W-1:0]    alphabet_low_chars;
  logic [atoiab_pkg::CFG_W-1:0]    alphabet_high_chars;
  logic [atoiab_pkg::LENREG_W-1:0] alphabet_length;

  logic [2*atoiab_pkg::CFG_W-1:0] alpha_all;
  logic [LEN_W-1:0]               used_len;
  logic                           alpha_ok_next;
  logic                           alpha_ok;

  // input stage
  logic               in_hit;
  logic [DIGIT_W-1:0] in_digit;
  logic               in_space;
  logic               in_sign;
  logic               s1_valid;
  logic               s1_last;
  logic               s1_space;
  logic               s1_sign;
  logic               s1_minus;
  logic               s1_hit;
  logic [DIGIT_W-1:0] s1_digit;
  logic               s1_go;

  // parse state
  atoiab_pkg::phase_t phase;
  atoiab_pkg::phase_t phase_next;
  logic               negative;
  logic               negative_next;
  logic [VW-1:0]      accumulator;
  logic [VW-1:0]      accumulator_next;
  logic [VW-1:0]      acc_mul;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_low_chars  <= atoiab_pkg::ALPHA_LOW_RST;
      alphabet_high_chars <= atoiab_pkg::ALPHA_HIGH_RST;
      alphabet_length     <= atoiab_pkg::ALPHA_LEN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        atoiab_pkg::REG_ALPHA_LOW:  alphabet_low_chars  <= cfg_data;
        atoiab_pkg::REG_ALPHA_HIGH: alphabet_high_chars <= cfg_data;
        atoiab_pkg::REG_ALPHA_LEN:  alphabet_length <= cfg_data[atoiab_pkg::LENREG_W-1:0];
        default: ;
      endcase
    end
  end

  assign alpha_all = {alphabet_high_chars, alphabet_low_chars};

  always_comb begin
    if (alphabet_length > atoiab_pkg::LENREG_W'(MAX_DIGITS)) begin
      used_len = LEN_W'(MAX_DIGITS);
    end else begin
      used_len = LEN_W'(alphabet_length);
    end
  end

  // alphabet check: length in range, no sign or zero byte, no duplicate
  always_comb begin
    alpha_ok_next = (alphabet_length >= atoiab_pkg::LENREG_W'(2)) &&
                    (alphabet_length <= atoiab_pkg::LENREG_W'(MAX_DIGITS));
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (atoiab_pkg::LENREG_W'(i) < alphabet_length) begin
        if (alpha_all[8*i +: 8] == atoiab_pkg::CHAR_NUL ||
            alpha_all[8*i +: 8] == atoiab_pkg::CHAR_PLUS ||
            alpha_all[8*i +: 8] == atoiab_pkg::CHAR_MINUS) begin
          alpha_ok_next = 1'b0;
        end
        for (int j = i + 1; j < MAX_DIGITS; j++) begin
          if (atoiab_pkg::LENREG_W'(j) < alphabet_length &&
              alpha_all[8*j +: 8] == alpha_all[8*i +: 8]) begin
            alpha_ok_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    alpha_ok <= alpha_ok_next;
  end

  // digit match, lowest index wins
  always_comb begin
    in_hit   = 1'b0;
    in_digit = '0;
    for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
      if (LEN_W'(k) < used_len && alpha_all[8*k +: 8] == char_code) begin
        in_hit   = 1'b1;
        in_digit = DIGIT_W'(k);
      end
    end
  end

  assign in_space = (char_code == atoiab_pkg::CHAR_SPACE) ||
                    (char_code >= atoiab_pkg::CHAR_TAB && char_code <= atoiab_pkg::CHAR_CR);
  assign in_sign  = (char_code == atoiab_pkg::CHAR_PLUS) ||
                    (char_code == atoiab_pkg::CHAR_MINUS);

  // a last character needs room in the output register
  assign s1_go    = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_last  <= is_last;
      s1_space <= in_space;
      s1_sign  <= in_sign;
      s1_minus <= (char_code == atoiab_pkg::CHAR_MINUS);
      s1_hit   <= in_hit;
      s1_digit <= in_digit;
    end
  end

  assign acc_mul = accumulator * VW'(used_len);

  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    accumulator_next = accumulator;
    if (phase == atoiab_pkg::PH_SPACE && s1_space) begin
      phase_next = phase;
    end else if ((phase == atoiab_pkg::PH_SPACE || phase == atoiab_pkg::PH_SIGN) && s1_sign) begin
      phase_next    = atoiab_pkg::PH_SIGN;
      negative_next = negative ^ s1_minus;
    end else if (phase != atoiab_pkg::PH_DONE) begin
      if (s1_hit) begin
        accumulator_next = acc_mul + VW'(s1_digit);
        phase_next       = atoiab_pkg::PH_DIGITS;
      end else begin
        phase_next = atoiab_pkg::PH_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= atoiab_pkg::PH_SPACE;
      negative    <= 1'b0;
      accumulator <= '0;
    end else if (s1_go) begin
      if (s1_last) begin
        phase       <= atoiab_pkg::PH_SPACE;
        negative    <= 1'b0;
        accumulator <= '0;
      end else begin
        phase       <= phase_next;
        negative    <= negative_next;
        accumulator <= accumulator_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      valid_res <= alpha_ok;
      if (!alpha_ok) begin
        value <= '0;
      end else if (negative_next) begin
        value <= $signed(VW'(0) - accumulator_next);
      end else begin
        value <= $signed(accumulator_next);
      end
    end
  end

endmodule
